### design/lz77_window_copy_core_macros.svh
// Assertion macros shared by the LZ77 window copy core.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef LZ77_WINDOW_COPY_CORE_MACROS_SVH
`define LZ77_WINDOW_COPY_CORE_MACROS_SVH

`define LZ77WC_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lz77 window copy check failed");

`define LZ77WC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lz77 window copy check failed");

`endif

### design/lz77wc_pkg.sv
// Shared constants, codes and controller/datapath interface types
// for the LZ77 window copy core. No dependencies.
package lz77wc_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 32768;
  localparam int unsigned LANES_DEF       = 8;
  localparam int unsigned MAX_MATCH       = 258;

  localparam logic [1:0] OP_LIT     = 2'd0;
  localparam logic [1:0] OP_COPY    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIST  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  typedef struct packed {
    logic lit_push;
    logic err_emit;
    logic copy_start;
    logic copy_push;
    logic restart;
  } lz77wc_cmd_t;

  typedef struct packed {
    logic rd_pend;
    logic emit_need;
    logic last_byte;
    logic out_free;
    logic dist_ok;
    logic len_zero;
  } lz77wc_sts_t;

endpackage

### design/lz77wc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// The read data holds while no read is enabled. No dependencies.
module lz77wc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/lz77wc_ctrl.sv
// Controller state machine of the LZ77 window copy core.
// Depends on lz77wc_pkg for op codes and the command and status types.
module lz77wc_ctrl
  import lz77wc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_op,
  input  lz77wc_sts_t sts,
  output logic        in_ready,
  output lz77wc_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_COPY = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_LIT: begin
              cmd.lit_push = 1'b1;
            end
            OP_COPY: begin
              if (!sts.dist_ok) begin
                cmd.err_emit = 1'b1;
              end else if (!sts.len_zero) begin
                cmd.copy_start = 1'b1;
                state_nxt      = S_COPY;
              end
            end
            OP_RESTART: begin
              cmd.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_COPY: begin
        cmd.copy_push = sts.rd_pend && (!sts.emit_need || sts.out_free);
        if (cmd.copy_push && sts.last_byte) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/lz77wc_datapath.sv
// Datapath of the LZ77 window copy core: history RAM, positions, byte count,
// lane packing and the result register. Depends on lz77wc_pkg and lz77wc_ram.
module lz77wc_datapath
  import lz77wc_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int unsigned LANES       = LANES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lz77wc_cmd_t cmd,
  output lz77wc_sts_t sts,
  input  logic [7:0]  in_literal,
  input  logic [8:0]  in_match_length,
  input  logic [15:0] in_match_distance,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_output_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last,
  output logic [1:0]  out_status
);

  localparam int unsigned AW    = $clog2(WINDOW_SIZE);
  localparam int unsigned FW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [31:0] WIN32 = 32'(WINDOW_SIZE);

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] src_r, src_nxt;
  logic [31:0]   bp_r, bp_nxt;
  logic [31:0]   limit_r;
  logic [8:0]    rem_r, rem_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [63:0]   word_r, word_nxt, word_emit;
  logic          rd_pend_r, rd_pend_nxt;
  logic          fwd_r;
  logic [7:0]    fwd_byte_r;

  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_bytes_r, out_bytes_nxt;
  logic [3:0]    out_count_r, out_count_nxt;
  logic          out_last_r, out_last_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic          push, emit, re, we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata, copy_byte, push_byte;
  logic [16:0]   diff;
  logic [AW-1:0] src_start;
  logic [8:0]    len_sat;
  logic [31:0]   bp_inc;

  function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
    return (p == AW'(WINDOW_SIZE - 1)) ? '0 : p + AW'(1);
  endfunction

  lz77wc_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_SIZE)
  ) u_hist (
    .clk  (clk),
    .we   (we),
    .waddr(wp_r),
    .wdata(push_byte),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign diff      = 17'(wp_r) - 17'(in_match_distance);
  assign src_start = diff[16] ? AW'(diff + 17'(WINDOW_SIZE)) : AW'(diff);
  assign len_sat   = (in_match_length > 9'(MAX_MATCH)) ? 9'(MAX_MATCH) : in_match_length;

  assign copy_byte = fwd_r ? fwd_byte_r : rdata;
  assign push_byte = cmd.lit_push ? in_literal : copy_byte;
  assign push      = cmd.lit_push || cmd.copy_push;
  assign we        = push;

  assign sts.rd_pend   = rd_pend_r;
  assign sts.last_byte = (rem_r == 9'd1);
  assign sts.emit_need = (fill_r == FW'(LANES - 1)) || sts.last_byte;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.dist_ok   = (in_match_distance != '0) && ({16'b0, in_match_distance} <= WIN32)
                         && ({16'b0, in_match_distance} <= bp_r);
  assign sts.len_zero  = (in_match_length == '0);

  assign re    = cmd.copy_start || (cmd.copy_push && !sts.last_byte);
  assign raddr = cmd.copy_start ? src_start : src_r;
  assign emit  = cmd.lit_push || (cmd.copy_push && sts.emit_need);

  assign bp_inc = (bp_r == '1) ? bp_r : bp_r + 32'd1;

  always_comb begin
    word_emit = word_r;
    for (int i = 0; i < int'(LANES); i++) begin
      if (fill_r == FW'(i)) begin
        word_emit[8*i +: 8] = push_byte;
      end
    end
  end

  always_comb begin
    wp_nxt         = wp_r;
    src_nxt        = src_r;
    bp_nxt         = bp_r;
    rem_nxt        = rem_r;
    fill_nxt       = fill_r;
    word_nxt       = word_r;
    rd_pend_nxt    = rd_pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_bytes_nxt  = out_bytes_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    if (re) begin
      rd_pend_nxt = 1'b1;
    end else if (cmd.copy_push) begin
      rd_pend_nxt = 1'b0;
    end

    if (cmd.copy_start) begin
      src_nxt  = pos_inc(src_start);
      rem_nxt  = len_sat;
      fill_nxt = '0;
      word_nxt = '0;
    end

    if (cmd.copy_push && !sts.last_byte) begin
      src_nxt = pos_inc(src_r);
    end

    if (push) begin
      wp_nxt   = pos_inc(wp_r);
      bp_nxt   = bp_inc;
      word_nxt = word_emit;
      fill_nxt = fill_r + FW'(1);
      if (cmd.copy_push) begin
        rem_nxt = rem_r - 9'd1;
      end
    end

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_bytes_nxt  = word_emit;
      out_count_nxt  = 4'(fill_r) + 4'd1;
      out_last_nxt   = cmd.lit_push || sts.last_byte;
      out_status_nxt = ((limit_r != '0) && (bp_inc > limit_r)) ? ST_LIMIT : ST_OK;
      fill_nxt       = '0;
      word_nxt       = '0;
    end

    if (cmd.err_emit) begin
      out_valid_nxt  = 1'b1;
      out_bytes_nxt  = '0;
      out_count_nxt  = 4'd0;
      out_last_nxt   = 1'b1;
      out_status_nxt = ST_DIST;
    end

    if (cmd.restart) begin
      wp_nxt = '0;
      bp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      bp_r        <= '0;
      limit_r     <= '0;
      rem_r       <= '0;
      fill_r      <= '0;
      word_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      bp_r        <= bp_nxt;
      rem_r       <= rem_nxt;
      fill_r      <= fill_nxt;
      word_r      <= word_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_output_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    if (re) begin
      fwd_r      <= we && (wp_r == raddr);
      fwd_byte_r <= push_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = out_bytes_r;
  assign out_byte_count = out_count_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

### design/lz77_window_copy_core.sv
// LZ77 window copy core: literals and length/distance copies over a circular
// history, bytes packed up to LANES to a result. A literal, a bad distance,
// a restart or an ignored op never enters the copy state. A match copies one
// history byte per cycle through the single read port of the history RAM,
// stalling while a result is due and the result register is not drained. The
// history is not cleared after reset or restart and needs no clearing pass:
// copies only reach bytes produced since then, which the byte count ensures.
// Depends on lz77wc_pkg, lz77wc_ctrl, lz77wc_datapath and the macros header.
`include "lz77_window_copy_core_macros.svh"

module lz77_window_copy_core
  import lz77wc_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int unsigned LANES       = LANES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_literal,
  input  logic [8:0]  in_match_length,
  input  logic [15:0] in_match_distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_output_limit
);

  lz77wc_cmd_t cmd;
  lz77wc_sts_t sts;

  assign cfg_ready = 1'b1;

  lz77wc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_op),
    .sts     (sts),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  lz77wc_datapath #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .LANES      (LANES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_literal       (in_literal),
    .in_match_length  (in_match_length),
    .in_match_distance(in_match_distance),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_output_limit (cfg_output_limit),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bytes        (out_bytes),
    .out_byte_count   (out_byte_count),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  `LZ77WC_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(cmd))
  `LZ77WC_ASSERT_NEXT(a_start_reads, cmd.copy_start, sts.rd_pend)
  `LZ77WC_ASSERT_IMPL(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
  `LZ77WC_ASSERT_IMPL(a_err_empty, out_valid && (out_status == ST_DIST),
                      out_last && (out_byte_count == 4'd0))

endmodule
